// ===== design/lsv_pkg.sv =====
package lsv_pkg;

   localparam int WORD_WIDTH_DEF    = 32;
   localparam int FRACTION_BITS_DEF = 16;

   // Pipeline depth of the front end (minors, cofactors, products, sums).
   localparam int FRONT_STAGES = 5;

   // Status that a division lane hands to the merging stage.
   typedef struct packed {
      logic big;   // quotient magnitude is at least two to the word width
      logic neg;   // quotient is negative
   } lane_flags_type;

   // Status of the determinant path.
   typedef struct packed {
      logic zero;  // exact determinant is zero
      logic sat;   // scaled determinant was clamped
   } det_flags_type;

endpackage

// ===== design/linear_solve_3x3_unit.sv =====
// Channel   Direction  Payload
// req_      in         tdata: a00 a01 a02 a10 a11 a12 a20 a21 a22 rhs0 rhs1 rhs2
// rsp_      out        tdata: sol0 sol1 sol2 det_value; tuser: singular overflow
//
// One system is taken per cycle unless every stage holds an item and the output
// is stalled; each result passes through the front end, the restoring divider in
// the three lanes, one quotient bit per stage, and the merging stage.
// Reset is synchronous and clears only the stage valid bits.
// A stalled output holds its result; stages behind it keep filling bubbles, so
// input is refused only once every stage holds an item.
module linear_solve_3x3_unit import lsv_pkg::*; #(
   parameter int WORD_WIDTH    = WORD_WIDTH_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // a00, a01, a02, a10, a11, a12, a20, a21, a22, rhs0, rhs1, rhs2
   input  logic [((12*WORD_WIDTH+7)/8)*8-1:0]      req_tdata,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // sol0, sol1, sol2, det_value
   output logic [((4*WORD_WIDTH+7)/8)*8-1:0]       rsp_tdata,
   // singular, overflow
   output logic [1:0]                              rsp_tuser
);

   localparam int W   = WORD_WIDTH;
   localparam int F   = FRACTION_BITS;
   localparam int DW  = 3 * W + 3;
   localparam int LS  = FRONT_STAGES;
   localparam int N   = LS + W + 2;
   localparam int OPW = ((4*W+7)/8)*8;

   logic [N-1:0] v_ff;
   logic [N-1:0] en;

   // A stage may load when it is empty or when the one after it moves.
   always_comb begin
      en[N-1] = !v_ff[N-1] || rsp_tready;
      for (int k = N - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < N; k++) begin
            if (en[k]) begin
               v_ff[k] <= (k == 0) ? req_tvalid : v_ff[(k == 0) ? 0 : k-1];
            end
         end
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = v_ff[N-1];

   logic signed [W-1:0]  a   [9];
   logic signed [W-1:0]  rhs [3];
   logic signed [DW-1:0] det;
   logic signed [DW-1:0] num [3];

   for (genvar gi = 0; gi < 9; gi++) begin : g_a
      assign a[gi] = $signed(req_tdata[gi*W +: W]);
   end
   for (genvar gi = 0; gi < 3; gi++) begin : g_b
      assign rhs[gi] = $signed(req_tdata[(9+gi)*W +: W]);
   end

   lsv_front #(
      .WORD_WIDTH(W)
   ) u_front (
      .clock(clock),
      .en(en[LS-1:0]),
      .a(a),
      .rhs(rhs),
      .det(det),
      .num(num)
   );

   logic [W-1:0]   qmag   [3];
   lane_flags_type lflags [3];

   for (genvar gl = 0; gl < 3; gl++) begin : g_lane
      lsv_lane #(
         .WORD_WIDTH(W), .FRACTION_BITS(F)
      ) u_lane (
         .clock(clock),
         .en(en[LS+W:LS]),
         .num(num[gl]),
         .det(det),
         .qmag(qmag[gl]),
         .flags(lflags[gl])
      );
   end

   // Determinant output, scaled and clamped, then delayed beside the lanes.
   logic signed [DW-1:0] det_sh_in;
   logic                 det_fit_in;
   logic signed [W-1:0]  dword_in;
   det_flags_type        dfl_in;
   logic signed [W-1:0]  dword_ff [W+1];
   det_flags_type        dfl_ff   [W+1];

   always_comb begin
      det_sh_in   = det >>> (2 * F);
      det_fit_in  = (&det_sh_in[DW-1:W-1]) || !(|det_sh_in[DW-1:W-1]);
      dfl_in.zero = det == '0;
      dfl_in.sat  = !det_fit_in;
      if (det_fit_in) begin
         dword_in = det_sh_in[W-1:0];
      end else begin
         dword_in = det_sh_in[DW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (en[LS]) begin
         dword_ff[0] <= dword_in;
         dfl_ff[0]   <= dfl_in;
      end
      for (int k = 1; k <= W; k++) begin
         if (en[LS+k]) begin
            dword_ff[k] <= dword_ff[k-1];
            dfl_ff[k]   <= dfl_ff[k-1];
         end
      end
   end

   logic signed [W-1:0] sol [3];
   logic signed [W-1:0] det_value;
   logic                singular;
   logic                overflow;

   lsv_merge #(
      .WORD_WIDTH(W)
   ) u_merge (
      .clock(clock),
      .en(en[N-1]),
      .qmag(qmag),
      .lflags(lflags),
      .det_word(dword_ff[W]),
      .dflags(dfl_ff[W]),
      .sol(sol),
      .det_value(det_value),
      .singular(singular),
      .overflow(overflow)
   );

   assign rsp_tdata = {{(OPW-4*W){1'b0}}, det_value, sol[2], sol[1], sol[0]};
   assign rsp_tuser = {overflow, singular};

   // A singular result carries zero values and no overflow.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && singular |-> !overflow && sol[0] == '0 && sol[1] == '0
                                 && sol[2] == '0 && det_value == '0)
      else $error("singular result with nonzero payload");

   // A transfer on the input must occupy the first stage.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> v_ff[0])
      else $error("accepted item lost at the first stage");

   // With every stage full and the output stalled, input must be refused.
   assert property (@(posedge clock) disable iff (reset)
      (&v_ff) && !rsp_tready |-> !req_tready)
      else $error("input accepted into a full pipeline");

endmodule

// ===== design/lsv_front.sv =====
module lsv_front import lsv_pkg::*; #(
   parameter int WORD_WIDTH    = WORD_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic [FRONT_STAGES-1:0]            en,
   input  logic signed [WORD_WIDTH-1:0]       a   [9],
   input  logic signed [WORD_WIDTH-1:0]       rhs [3],
   output logic signed [3*WORD_WIDTH+2:0]     det,
   output logic signed [3*WORD_WIDTH+2:0]     num [3]
);

   localparam int W  = WORD_WIDTH;
   localparam int CW = 2 * W + 1;
   localparam int PW = 3 * W + 1;
   localparam int DW = 3 * W + 3;

   logic signed [2*W-1:0] pa_ff [9];
   logic signed [2*W-1:0] pb_ff [9];
   logic signed [CW-1:0]  cof_ff [9];
   logic signed [W-1:0]   a0_s1_ff [3];
   logic signed [W-1:0]   a0_s2_ff [3];
   logic signed [W-1:0]   rhs_s1_ff [3];
   logic signed [W-1:0]   rhs_s2_ff [3];
   logic signed [2*W:0]   lo_ff [12];
   logic signed [2*W:0]   hi_ff [12];
   logic signed [PW-1:0]  prod_ff [12];
   logic signed [DW-1:0]  det_ff;
   logic signed [DW-1:0]  num_ff [3];

   // Minors: two products for each of the nine positions.
   for (genvar gr = 0; gr < 3; gr++) begin : g_row
      for (genvar gc = 0; gc < 3; gc++) begin : g_col
         localparam int R1 = (gr == 0) ? 1 : 0;
         localparam int R2 = (gr == 2) ? 1 : 2;
         localparam int C1 = (gc == 0) ? 1 : 0;
         localparam int C2 = (gc == 2) ? 1 : 2;
         logic signed [CW-1:0] mn_in;

         always_ff @(posedge clock) begin
            if (en[0]) begin
               pa_ff[gr*3+gc] <= a[R1*3+C1] * a[R2*3+C2];
               pb_ff[gr*3+gc] <= a[R1*3+C2] * a[R2*3+C1];
            end
         end

         assign mn_in = $signed({pa_ff[gr*3+gc][2*W-1], pa_ff[gr*3+gc]})
                      - $signed({pb_ff[gr*3+gc][2*W-1], pb_ff[gr*3+gc]});

         // Odd positions carry the negative cofactor sign.
         always_ff @(posedge clock) begin
            if (en[1]) begin
               cof_ff[gr*3+gc] <= (((gr + gc) % 2) == 1) ? -mn_in : mn_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         a0_s1_ff  <= a[0:2];
         rhs_s1_ff <= rhs;
      end
      if (en[1]) begin
         a0_s2_ff  <= a0_s1_ff;
         rhs_s2_ff <= rhs_s1_ff;
      end
   end

   // Products of a word and a cofactor, split into a low-word and a high partial.
   // The first three feed the determinant, the rest the three numerators.
   for (genvar gp = 0; gp < 12; gp++) begin : g_prod
      localparam int I = (gp < 3) ? 0 : (gp - 3) / 3;
      localparam int R = (gp < 3) ? 0 : (gp - 3) % 3;
      logic signed [W-1:0]  x_in;
      logic signed [CW-1:0] c_in;

      assign x_in = (gp < 3) ? a0_s2_ff[gp % 3] : rhs_s2_ff[R];
      assign c_in = (gp < 3) ? cof_ff[gp % 3] : cof_ff[R*3+I];

      always_ff @(posedge clock) begin
         if (en[2]) begin
            lo_ff[gp] <= x_in * $signed({1'b0, c_in[W-1:0]});
            hi_ff[gp] <= x_in * $signed(c_in[CW-1:W]);
         end
         if (en[3]) begin
            prod_ff[gp] <= $signed({hi_ff[gp], {W{1'b0}}})
                         + $signed({{W{lo_ff[gp][2*W]}}, lo_ff[gp]});
         end
      end
   end

   function automatic logic signed [DW-1:0] ext(input logic signed [PW-1:0] p);
      ext = $signed({{(DW-PW){p[PW-1]}}, p});
   endfunction

   always_ff @(posedge clock) begin
      if (en[4]) begin
         det_ff <= ext(prod_ff[0]) + ext(prod_ff[1]) + ext(prod_ff[2]);
         for (int i = 0; i < 3; i++) begin
            num_ff[i] <= ext(prod_ff[3+3*i]) + ext(prod_ff[4+3*i])
                       + ext(prod_ff[5+3*i]);
         end
      end
   end

   assign det = det_ff;
   assign num = num_ff;

endmodule

// ===== design/lsv_lane.sv =====
module lsv_lane import lsv_pkg::*; #(
   parameter int WORD_WIDTH    = WORD_WIDTH_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                            clock,
   input  logic [WORD_WIDTH:0]             en,
   input  logic signed [3*WORD_WIDTH+2:0]  num,
   input  logic signed [3*WORD_WIDTH+2:0]  det,
   output logic [WORD_WIDTH-1:0]           qmag,
   output lane_flags_type                  flags
);

   localparam int W  = WORD_WIDTH;
   localparam int F  = FRACTION_BITS;
   localparam int DW = 3 * W + 3;
   localparam int NW = DW + F;
   localparam int XW = NW + W;

   logic [NW-1:0]  rem_ff [W+1];
   logic [DW-1:0]  dm_ff  [W+1];
   logic [W-1:0]   q_ff   [W+1];
   lane_flags_type fl_ff  [W+1];

   logic [NW-1:0]  sh_in;
   logic [NW-1:0]  mag_in;
   logic [DW-1:0]  dmag_in;
   lane_flags_type fl_in;

   always_comb begin
      sh_in   = {num, {F{1'b0}}};
      mag_in  = num[DW-1] ? (~sh_in + 1'b1) : sh_in;
      dmag_in = det[DW-1] ? (~det + 1'b1) : det;
      fl_in.neg = num[DW-1] ^ det[DW-1];
      fl_in.big = {{W{1'b0}}, mag_in} >= {{F{1'b0}}, dmag_in, {W{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rem_ff[0] <= mag_in;
         dm_ff[0]  <= dmag_in;
         q_ff[0]   <= '0;
         fl_ff[0]  <= fl_in;
      end
   end

   // One restoring step per stage, most significant quotient bit first.
   // Without the big flag the remainder stays below the shifted divisor.
   for (genvar gk = 1; gk <= W; gk++) begin : g_step
      localparam int J = W - gk;
      logic [XW-1:0] trial_in;
      logic [XW-1:0] remx_in;
      logic [XW-1:0] diff_in;
      logic          ge_in;
      logic [W-1:0]  q_in;

      always_comb begin
         trial_in = {{(F+W){1'b0}}, dm_ff[gk-1]} << J;
         remx_in  = {{W{1'b0}}, rem_ff[gk-1]};
         ge_in    = remx_in >= trial_in;
         diff_in  = remx_in - trial_in;
         q_in     = q_ff[gk-1];
         q_in[J]  = ge_in;
      end

      always_ff @(posedge clock) begin
         if (en[gk]) begin
            rem_ff[gk] <= ge_in ? diff_in[NW-1:0] : rem_ff[gk-1];
            dm_ff[gk]  <= dm_ff[gk-1];
            q_ff[gk]   <= q_in;
            fl_ff[gk]  <= fl_ff[gk-1];
         end
      end
   end

   assign qmag  = q_ff[W];
   assign flags = fl_ff[W];

endmodule

// ===== design/lsv_merge.sv =====
module lsv_merge import lsv_pkg::*; #(
   parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic [WORD_WIDTH-1:0]        qmag [3],
   input  lane_flags_type               lflags [3],
   input  logic signed [WORD_WIDTH-1:0] det_word,
   input  det_flags_type                dflags,
   output logic signed [WORD_WIDTH-1:0] sol [3],
   output logic signed [WORD_WIDTH-1:0] det_value,
   output logic                         singular,
   output logic                         overflow
);

   localparam int W = WORD_WIDTH;
   localparam logic [W-1:0] MAX_WORD = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MIN_WORD = {1'b1, {(W-1){1'b0}}};

   logic signed [W-1:0] sol_ff [3];
   logic signed [W-1:0] det_ff;
   logic                singular_ff;
   logic                overflow_ff;

   logic signed [W-1:0] sol_in [3];
   logic [2:0]          sat_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sat_in[i] = 1'b0;
         if (lflags[i].big) begin
            sat_in[i] = 1'b1;
            sol_in[i] = lflags[i].neg ? MIN_WORD : MAX_WORD;
         end else if (lflags[i].neg) begin
            sat_in[i] = qmag[i] > MIN_WORD;
            sol_in[i] = sat_in[i] ? MIN_WORD : (~qmag[i] + 1'b1);
         end else begin
            sat_in[i] = qmag[i][W-1];
            sol_in[i] = sat_in[i] ? MAX_WORD : qmag[i];
         end
         if (dflags.zero) begin
            sol_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sol_ff      <= sol_in;
         det_ff      <= dflags.zero ? '0 : det_word;
         singular_ff <= dflags.zero;
         overflow_ff <= !dflags.zero && ((|sat_in) || dflags.sat);
      end
   end

   assign sol       = sol_ff;
   assign det_value = det_ff;
   assign singular  = singular_ff;
   assign overflow  = overflow_ff;

endmodule
